// ===== design/bsq_pkg.sv =====
// ----------------------------------------------------------------------------
// bsq_pkg: shared types and constants for the byte stack/queue core
// Beat structs, request and register codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package bsq_pkg;

  // Default sizing, handed to the top level parameters
  localparam int STORE_BYTES_DEF    = 256;
  localparam int MAX_ELEM_BYTES_DEF = 8;

  // Configuration port sizing and register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'd1;

  // Capacity after reset
  localparam logic [8:0] CAPACITY_RESET = 9'd256;

  // Request codes
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  // Queue mode codes
  localparam logic MODE_LIFO = 1'b0;
  localparam logic MODE_FIFO = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } bsq_state_t;

  // Input beat
  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  elem_bytes;
    logic [63:0] push_data;
  } bsq_in_t;

  // Result beat
  typedef struct packed {
    logic [63:0] read_data;
    logic        status;
    logic        now_empty;
    logic        now_full;
    logic [8:0]  fill_level;
  } bsq_out_t;

endpackage

`default_nettype wire

// ===== design/bsq_ram.sv =====
// ----------------------------------------------------------------------------
// bsq_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write or read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else if (re) begin
      rdata <= mem_r[addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/byte_stack_queue_core.sv =====
// ----------------------------------------------------------------------------
// byte_stack_queue_core: byte-wide LIFO/FIFO buffer with push, pop and peek
// Held bytes form a run in a ring store; elements of 1 to 8 bytes move
// through the store one byte per cycle.
// ----------------------------------------------------------------------------
//   channel  | ports                          | handshake
//   ---------+--------------------------------+-------------------------------
//   input    | start, busy, in_item           | taken when start && !busy
//   result   | out_strobe, out_result         | one-cycle strobe, no stall
//   config   | cfg_we, cfg_index, cfg_data    | written when cfg_we
//
// A push steps through the push and finish states, a pop or peek through
// read, drain and finish, a reject through finish alone; the single byte
// port of the store moves one byte per cycle. The result beat shows in the
// last busy cycle. Reset is synchronous and clears the pointers and fill
// count; the store itself is not cleared. The result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stack_queue_core #(
  parameter int STORE_BYTES    = bsq_pkg::STORE_BYTES_DEF,
  parameter int MAX_ELEM_BYTES = bsq_pkg::MAX_ELEM_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire bsq_pkg::bsq_in_t               in_item,
  output logic                                out_strobe,
  output bsq_pkg::bsq_out_t                   out_result,
  input  wire logic                           cfg_we,
  input  wire logic [bsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bsq_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [8:0] CAP_LIMIT = 9'((STORE_BYTES > 511) ? 511 : STORE_BYTES);
  localparam logic [3:0] ELEM_MAX  = 4'(MAX_ELEM_BYTES);
  localparam logic [AW:0]   STORE_W = (AW+1)'(STORE_BYTES);
  localparam logic [AW-1:0] POS_TOP = AW'(STORE_BYTES - 1);

  // Ring position helpers
  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == POS_TOP) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
    return (p == '0) ? POS_TOP : p - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p, input logic [3:0] k);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(k);
    if (s >= STORE_W) begin
      s = s - STORE_W;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] p, input logic [3:0] k);
    logic [AW:0] s;
    if ({1'b0, p} >= (AW+1)'(k)) begin
      s = {1'b0, p} - (AW+1)'(k);
    end else begin
      s = {1'b0, p} + STORE_W - (AW+1)'(k);
    end
    return s[AW-1:0];
  endfunction

  // Control and configuration registers
  bsq_pkg::bsq_state_t state_r, state_nxt;
  logic          mode_r;
  logic [8:0]    cap_r;
  logic [8:0]    held_r, held_nxt;
  logic [AW-1:0] top_r, top_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic          rvalid_r;

  // Datapath registers
  logic [63:0]   sh_r, sh_nxt;
  logic [63:0]   rd_r, rd_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          status_r, status_nxt;

  // Store port
  logic          ram_we, ram_re;
  logic [7:0]    ram_rdata;

  // Request decode
  logic [8:0]    cap_eff;
  logic [3:0]    n;
  logic          size_ok, push_ok, read_ok, is_read;
  logic [AW-1:0] read_last;

  assign cap_eff = (cap_r > CAP_LIMIT) ? CAP_LIMIT : cap_r;
  assign n       = in_item.elem_bytes;
  assign size_ok = (n != 4'd0) && (n <= ELEM_MAX);
  assign is_read = (in_item.req_type == bsq_pkg::REQ_POP) ||
                   (in_item.req_type == bsq_pkg::REQ_PEEK);
  assign push_ok = (in_item.req_type == bsq_pkg::REQ_PUSH) && size_ok &&
                   (({1'b0, held_r} + 10'(n)) <= {1'b0, cap_eff});
  assign read_ok = is_read && size_ok && (held_r >= 9'(n));
  // Highest address of the element; bytes are read downward from here
  assign read_last = (mode_r == bsq_pkg::MODE_FIFO) ? ring_add(oldest_r, n - 4'd1)
                                                    : ring_dec(top_r);

  // Sequence one request
  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    top_nxt    = top_r;
    oldest_nxt = oldest_r;
    sh_nxt     = sh_r;
    rd_nxt     = rd_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    // Collect one byte from the store, lowest address ends lowest
    if (rvalid_r) begin
      rd_nxt = {rd_r[55:0], ram_rdata};
    end

    case (state_r)
      bsq_pkg::ST_IDLE: begin
        if (start) begin
          rd_nxt   = '0;
          cnt_nxt  = n;
          sh_nxt   = in_item.push_data;
          if (push_ok) begin
            status_nxt = 1'b0;
            addr_nxt   = top_r;
            top_nxt    = ring_add(top_r, n);
            held_nxt   = held_r + 9'(n);
            state_nxt  = bsq_pkg::ST_PUSH;
          end else if (read_ok) begin
            status_nxt = 1'b0;
            addr_nxt   = read_last;
            state_nxt  = bsq_pkg::ST_READ;
            // Drop the bytes on a pop
            if (in_item.req_type == bsq_pkg::REQ_POP) begin
              held_nxt = held_r - 9'(n);
              if (mode_r == bsq_pkg::MODE_FIFO) begin
                oldest_nxt = ring_add(oldest_r, n);
              end else begin
                top_nxt = ring_sub(top_r, n);
              end
            end
          end else begin
            status_nxt = 1'b1;
            state_nxt  = bsq_pkg::ST_FINISH;
          end
        end
      end
      bsq_pkg::ST_PUSH: begin
        // Write one byte, advance upward
        ram_we   = 1'b1;
        sh_nxt   = {8'd0, sh_r[63:8]};
        addr_nxt = ring_inc(addr_r);
        cnt_nxt  = cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          state_nxt = bsq_pkg::ST_FINISH;
        end
      end
      bsq_pkg::ST_READ: begin
        // Read one byte, advance downward
        ram_re   = 1'b1;
        addr_nxt = ring_dec(addr_r);
        cnt_nxt  = cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          state_nxt = bsq_pkg::ST_DRAIN;
        end
      end
      bsq_pkg::ST_DRAIN: begin
        state_nxt = bsq_pkg::ST_FINISH;
      end
      bsq_pkg::ST_FINISH: begin
        state_nxt = bsq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bsq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bsq_pkg::ST_IDLE;
      held_r   <= '0;
      top_r    <= '0;
      oldest_r <= '0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      top_r    <= top_nxt;
      oldest_r <= oldest_nxt;
      rvalid_r <= ram_re;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bsq_pkg::MODE_LIFO;
      cap_r  <= bsq_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsq_pkg::CFG_QUEUE_MODE: mode_r <= cfg_data[0];
        bsq_pkg::CFG_CAPACITY:   cap_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    sh_r     <= sh_nxt;
    rd_r     <= rd_nxt;
    addr_r   <= addr_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
  end

  bsq_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (addr_r),
    .wdata (sh_r[7:0]),
    .rdata (ram_rdata)
  );

  // Result beat
  assign busy                  = (state_r != bsq_pkg::ST_IDLE);
  assign out_strobe            = (state_r == bsq_pkg::ST_FINISH);
  assign out_result.read_data  = rd_r;
  assign out_result.status     = status_r;
  assign out_result.now_empty  = (held_r == 9'd0);
  assign out_result.now_full   = (held_r >= cap_eff);
  assign out_result.fill_level = held_r;

endmodule

`default_nettype wire

// ===== design/bsq_checker.sv =====
// ----------------------------------------------------------------------------
// bsq_checker: port-level checks for the byte stack/queue core
// Watches the handshake and result beats; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsq_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_strobe,
  input wire bsq_pkg::bsq_out_t out_result
);

  // A taken request keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // Results appear only while a request is in work
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result beat outside a request");

  // One result beat per request
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!out_strobe && !busy))
    else $error("result beat repeated");

  // Rejected requests return no data
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.status) |-> (out_result.read_data == 64'd0))
    else $error("rejected request returned data");

  // Empty flag agrees with fill level
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_result.now_empty == (out_result.fill_level == 9'd0)))
    else $error("empty flag disagrees with fill level");

endmodule

bind byte_stack_queue_core bsq_checker u_bsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_result (out_result)
);

`default_nettype wire
